FILE: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, command codes and defaults for the sorted-table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int VALUE_W         = 32;
    localparam int INDEX_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int PROBE_W         = 4;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

endpackage

FILE: rtl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a host-loaded ascending table of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries load and search items. A load
//   writes entry_value at entry_index and gives no result; loads at an index
//   at or beyond TABLE_DEPTH are dropped. A search walks the table held in a
//   single-port-read RAM, one probe per cycle: the compare of the registered
//   read data also forms the next midpoint address. A search probes at most
//   clog2(TABLE_DEPTH + 1) entries (11 for 1024 entries); an empty table is
//   not probed. The result (found, probe_count) sits in an output register on
//   the out_valid / out_stall channel; probe_count is 0 when found is 0.
//   A stalled result holds, and an idle block still accepts items meanwhile; a
//   search that completes while the output register is full and stalled
//   waits in a hold state with in_stall high. entry_count is written through
//   cfg_wr_en / cfg_wr_data; the user must write it only while idle, which
//   the block does not enforce. The count in use is clamped to TABLE_DEPTH.
//   Reset clears the count and the handshake state; the table contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [COUNT_W-1:0]        cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [INDEX_W-1:0]        entry_index,
    input  logic signed [VALUE_W-1:0] entry_value,
    input  logic signed [VALUE_W-1:0] search_key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [PROBE_W-1:0]        probe_count
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PROBE,
        ST_HOLD
    } state_t;

    state_t                     state_reg,       state_next;
    logic [CNT_W-1:0]           low_reg,         low_next;
    logic [CNT_W-1:0]           hi_reg,          hi_next;
    logic [ADDR_W-1:0]          mid_reg,         mid_next;
    logic signed [VALUE_W-1:0]  key_reg,         key_next;
    logic [PROBE_W-1:0]         probe_reg,       probe_next;
    logic                       hit_reg,         hit_next;
    logic                       out_valid_reg,   out_valid_next;
    logic                       found_reg,       found_next;
    logic [PROBE_W-1:0]         probe_count_reg, probe_count_next;
    logic [COUNT_W-1:0]         entry_count_reg;

    logic                       in_accept;
    logic                       out_free;
    logic [CNT_W-1:0]           n_cnt;
    logic [ADDR_W-1:0]          mid_first;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;
    logic signed [VALUE_W-1:0]  probe_val;
    logic                       key_eq;
    logic                       key_lt;
    logic [CNT_W-1:0]           mid_ext;
    logic [CNT_W-1:0]           lo_step;
    logic [CNT_W-1:0]           hi_step;
    logic [ADDR_W-1:0]          mid_step;
    logic [PROBE_W-1:0]         probe_inc;
    logic                       done;
    logic                       done_hit;
    logic [PROBE_W-1:0]         done_probes;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // count in use, clamped to the table depth
    assign n_cnt = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(entry_count_reg);
    assign mid_first = ADDR_W'((n_cnt - CNT_W'(1)) >> 1);

    assign ram_we = in_accept && (command == CMD_LOAD)
                    && (32'(entry_index) < 32'(TABLE_DEPTH));

    // one probe: compare the entry read for mid_reg, narrow [low, hi)
    assign probe_val = $signed(ram_rdata);
    assign key_eq    = (key_reg == probe_val);
    assign key_lt    = (key_reg < probe_val);
    assign mid_ext   = CNT_W'(mid_reg);
    assign lo_step   = key_lt ? low_reg : mid_ext + CNT_W'(1);
    assign hi_step   = key_lt ? mid_ext : hi_reg;
    assign mid_step  = ADDR_W'(lo_step + ((hi_step - lo_step - CNT_W'(1)) >> 1));
    assign probe_inc = (probe_reg == PROBE_MAX) ? probe_reg : probe_reg + PROBE_W'(1);

    assign ram_raddr = (state_reg == ST_PROBE) ? mid_step : mid_first;

    sts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (entry_value),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        low_next         = low_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        probe_next       = probe_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        probe_count_next = probe_count_reg;
        done             = 1'b0;
        done_hit         = 1'b0;
        done_probes      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_SEARCH))
                begin
                    key_next   = search_key;
                    low_next   = '0;
                    hi_next    = n_cnt;
                    mid_next   = mid_first;
                    probe_next = '0;
                    if (n_cnt == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                probe_next = probe_inc;
                if (key_eq)
                begin
                    done        = 1'b1;
                    done_hit    = 1'b1;
                    done_probes = probe_inc;
                end
                else if (lo_step < hi_step)
                begin
                    low_next = lo_step;
                    hi_next  = hi_step;
                    mid_next = mid_step;
                end
                else
                begin
                    done = 1'b1;
                end
                if (done)
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        found_next       = done_hit;
                        probe_count_next = done_probes;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        hit_next   = done_hit;
                        probe_next = done_probes;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    probe_count_next = hit_reg ? probe_reg : '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            low_reg         <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            key_reg         <= '0;
            probe_reg       <= '0;
            hit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            probe_count_reg <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            low_reg         <= low_next;
            hi_reg          <= hi_next;
            mid_reg         <= mid_next;
            key_reg         <= key_next;
            probe_reg       <= probe_next;
            hit_reg         <= hit_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            probe_count_reg <= probe_count_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign probe_count = probe_count_reg;

    // a miss never reports probes, a hit always reports at least one
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> probe_count_reg == '0)
        else $error("miss reported with nonzero probe count");

    a_hit_probes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> probe_count_reg != '0)
        else $error("hit reported with zero probe count");

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> (low_reg < hi_reg) && (CNT_W'(mid_reg) >= low_reg)
                                  && (CNT_W'(mid_reg) < hi_reg))
        else $error("probe outside search window");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE)
        else $error("table written during a search");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && command == CMD_SEARCH |=> in_stall)
        else $error("search accepted without going busy");

endmodule

FILE: rtl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/sorted_table_binary_search_test.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_test
// Loads ascending tables of several sizes, then searches them with keys that
// hit, near-miss or are random. A shadow copy of the table and of entry_count
// predicts found/probe_count, which are checked in order against the output
// channel. Both channels idle and stall at random, with one long output stall.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_test;
    import sts_pkg::*;

    localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AFTER     = 40;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        cmd_t                      command;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] search_key;
    } table_op_t;

    typedef struct packed {
        logic               found;
        logic [PROBE_W-1:0] probe_count;
    } lookup_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]        cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      command = 1'b0;
    logic [INDEX_W-1:0]        entry_index = '0;
    logic signed [VALUE_W-1:0] entry_value = '0;
    logic signed [VALUE_W-1:0] search_key = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      found;
    logic [PROBE_W-1:0]        probe_count;

    // stimulus side
    table_op_t                 pending_items[$];
    logic signed [VALUE_W-1:0] staged_entries[TABLE_DEPTH];
    int                        items_queued = 0;
    int                        send_gap_pct = 30;
    int                        recv_stall_pct = 64;

    // prediction side
    logic signed [VALUE_W-1:0] shadow_entries[TABLE_DEPTH];
    int                        count_model = 0;
    lookup_t                   lookups_due[$];
    table_op_t                 cur_item;
    int                        items_accepted = 0;
    int                        loads_done = 0;
    int                        searches_done = 0;

    // checking side
    int                        results_checked = 0;
    int                        hits_seen = 0;
    int                        deepest_hit = 0;
    int                        mismatches = 0;
    int                        hold_left = 0;
    logic                      long_hold_done = 1'b0;
    int                        quiet_cycles = 0;

    sorted_table_binary_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .probe_count (probe_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Binary search over the shadow table, count clamped to the depth.
    function automatic lookup_t predict_lookup(input logic signed [VALUE_W-1:0] key);
        lookup_t r;
        int      lo;
        int      hi;
        int      mid;
        int      probes;
        lo = 0;
        hi = ((count_model > TABLE_DEPTH) ? TABLE_DEPTH : count_model) - 1;
        probes = 0;
        r.found = 1'b0;
        while (lo <= hi && !r.found)
        begin
            mid = lo + (hi - lo) / 2;
            probes++;
            if (shadow_entries[mid] == key)
                r.found = 1'b1;
            else if (key < shadow_entries[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        r.probe_count = !r.found ? '0 :
                        (probes > PROBE_MAX ? PROBE_MAX : probes[PROBE_W-1:0]);
        return r;
    endfunction

    // Input driver; also feeds accepted items to the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                items_accepted++;
                if (cur_item.command == CMD_LOAD)
                begin
                    // every 10-bit index is below the depth, so no load is dropped
                    shadow_entries[cur_item.entry_index] = cur_item.entry_value;
                    loads_done++;
                end
                else
                begin
                    lookups_due.push_back(predict_lookup(cur_item.search_key));
                    searches_done++;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    cur_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    command     <= cur_item.command;
                    entry_index <= cur_item.entry_index;
                    entry_value <= cur_item.entry_value;
                    search_key  <= cur_item.search_key;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result checker and output stall.
    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (lookups_due.size() == 0)
                begin
                    $display("%0t: result with no search outstanding: found=%0b probes=%0d",
                             $time, found, probe_count);
                    mismatches++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0b, actual %0b",
                                 $time, want.found, found);
                        mismatches++;
                    end
                    if (probe_count !== want.probe_count)
                    begin
                        $display("%0t: probe_count expected %0d, actual %0d",
                                 $time, want.probe_count, probe_count);
                        mismatches++;
                    end
                    if (want.found)
                    begin
                        hits_seen++;
                        if (want.probe_count > deepest_hit)
                            deepest_hit = want.probe_count;
                    end
                end
            end
            // one long hold so the result register fills and the input backs up
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!long_hold_done && results_checked >= HOLD_AFTER)
            begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                out_stall      <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_load(input int idx, input logic signed [VALUE_W-1:0] value);
        table_op_t op;
        op.command     = CMD_LOAD;
        op.entry_index = idx[INDEX_W-1:0];
        op.entry_value = value;
        op.search_key  = $urandom;
        staged_entries[op.entry_index] = value;
        pending_items.push_back(op);
        items_queued++;
    endtask

    task automatic push_search(input logic signed [VALUE_W-1:0] key);
        table_op_t op;
        op.command     = CMD_SEARCH;
        op.entry_index = INDEX_W'($urandom);
        op.entry_value = $urandom;
        op.search_key  = key;
        pending_items.push_back(op);
        items_queued++;
    endtask

    // Entries 0..n-1 ascending; small steps now and then give duplicates.
    task automatic fill_ascending(input int n);
        longint v;
        v = longint'($urandom_range(0, 32'hBFFF_FFFF)) - 64'sd2147483648;
        for (int i = 0; i < n; i++)
        begin
            push_load(i, v[VALUE_W-1:0]);
            v += ($urandom_range(3) == 0) ? $urandom_range(0, 2)
                                           : $urandom_range(0, 1 << 20);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_key(input int span);
        int                        sel;
        logic signed [VALUE_W-1:0] k;
        sel = $urandom_range(0, 9);
        k = $urandom;
        if (span > 0 && sel < 5)
            k = staged_entries[$urandom_range(0, span - 1)];
        else if (span > 0 && sel < 7)
            k = staged_entries[$urandom_range(0, span - 1)] + ($urandom_range(1) ? 1 : -1);
        return k;
    endfunction

    // Wait for all items taken and all results in, then let a search finish.
    task automatic drain();
        while (items_accepted != items_queued || lookups_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[COUNT_W-1:0];
        count_model = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int reload_n, input int n_searches,
                             input int s_pct, input int r_pct);
        int span;
        int idx;
        send_gap_pct   = s_pct;
        recv_stall_pct = r_pct;
        write_count(count);
        span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        if (reload_n > 0)
            fill_ascending(reload_n);
        // sometimes break the ordering
        if (reload_n > 0 && $urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) push_load($urandom_range(0, reload_n - 1), $urandom);
        repeat (n_searches)
        begin
            if ($urandom_range(9) == 0)
            begin
                idx = $urandom_range(0, TABLE_DEPTH - 1);
                push_load(idx, staged_entries[idx]);
            end
            push_search(pick_key(span));
        end
        drain();
    endtask

    initial
    begin
        int count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        write_count(0);
        push_search(VALUE_MIN);
        push_search(VALUE_MAX);
        push_search(0);
        drain();

        // seven entries spanning the value range, plus the top index
        write_count(7);
        push_load(0, VALUE_MIN);
        push_load(1, -5);
        push_load(2, -1);
        push_load(3, 0);
        push_load(4, 1);
        push_load(5, 100);
        push_load(6, VALUE_MAX);
        push_load(TABLE_DEPTH - 1, -1);
        push_search(VALUE_MIN);
        push_search(VALUE_MAX);
        push_search(0);
        push_search(100);
        push_search(2);
        push_search(VALUE_MIN + 1);
        drain();

        // single entry
        write_count(1);
        push_search(VALUE_MIN);
        push_search(5);
        drain();

        // out of order table: present keys can be missed
        write_count(7);
        push_load(1, 1000);
        push_search(-5);
        push_search(1000);
        push_search(-1);
        drain();

        // full depth, then a count above the depth
        run_phase(TABLE_DEPTH, TABLE_DEPTH, 40, 30, 64);
        run_phase((1 << COUNT_W) - 1, 0, 20, 30, 64);

        for (int k = 0; k < 10; k++)
        begin
            case ($urandom_range(0, 9))
                0:       count = 0;
                1:       count = 1;
                2:       count = 2;
                3:       count = $urandom_range(TABLE_DEPTH, (1 << COUNT_W) - 1);
                default: count = $urandom_range(3, 24);
            endcase
            if (k < 2)
                run_phase(count, (count <= 64) ? count : 0, 10, 30, 64);
            else if (k < 6)
                run_phase(count, (count <= 64) ? count : 0, 10, 64, 30);
            else
                run_phase(count, (count <= 64) ? count : 0, 10, 0, 0);
        end

        $display("summary: %0d loads and %0d searches, counts 0 to %0d, three idling mixes",
                 loads_done, searches_done, (1 << COUNT_W) - 1);
        $display("summary: %0d hits, %0d misses, deepest hit %0d probes, %0d mismatches",
                 hits_seen, searches_done - hits_seen, deepest_hit, mismatches);
        if (mismatches == 0 && lookups_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_test.sv
